FILE: rtl/log_line_keyword_classifier_core_macros.svh
// assertion macros for the log line keyword classifier
// used by modules that clock on clk and reset on rst
`ifndef LOG_LINE_KEYWORD_CLASSIFIER_CORE_MACROS_SVH
`define LOG_LINE_KEYWORD_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define LLKC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLKC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/llkc_pkg.sv
// shared types, constants and helpers of the log line keyword classifier
// no dependencies
package llkc_pkg;

  localparam int LINE_BUFFER_DEF  = 1024;
  localparam int SEARCH_CHARS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 32;

  localparam int WINDOW   = 15;
  localparam int VIS_W    = $clog2(WINDOW + 1);
  localparam int NUM_KEYS = 8;
  localparam int KEY_MAX  = 9;
  localparam int OUT_W    = 32;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic [2:0] CLASS_INFO    = 3'd0;
  localparam logic [2:0] CLASS_WARNING = 3'd1;
  localparam logic [2:0] CLASS_ERROR   = 3'd2;
  localparam logic [2:0] CLASS_DEBUG   = 3'd3;
  localparam logic [2:0] CLASS_UNKNOWN = 3'd4;
  localparam int NUM_CLASSES = 5;

  localparam logic [2:0] FILT_ALL     = 3'd0;
  localparam logic [2:0] FILT_ERROR   = 3'd1;
  localparam logic [2:0] FILT_WARNING = 3'd2;
  localparam logic [2:0] FILT_INFO    = 3'd3;
  localparam logic [2:0] FILT_DEBUG   = 3'd4;

  localparam logic [1:0] REG_TYPE_FILTER = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW   = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH  = 2'd2;
  localparam logic [1:0] REG_SEARCH_LEN  = 2'd3;

  // last keyword character sits in bits 7:0
  localparam logic [KEY_MAX*8-1:0] KEY_TEXT [NUM_KEYS] = '{
    72'("[info]"), 72'("info:"), 72'("[warning]"), 72'("warning:"),
    72'("[error]"), 72'("error:"), 72'("[debug]"), 72'("debug:")
  };
  localparam logic [4:0] KEY_LEN [NUM_KEYS] = '{
    5'd6, 5'd5, 5'd9, 5'd8, 5'd7, 5'd6, 5'd7, 5'd6
  };
  localparam logic [1:0] KEY_CLASS [NUM_KEYS] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
  };

  typedef struct packed {
    logic       close;
    logic [3:0] hits;
    logic       text_ok;
  } line_ev_t;

  typedef struct packed {
    logic [OUT_W-1:0] unknown_total;
    logic [OUT_W-1:0] debug_total;
    logic [OUT_W-1:0] error_total;
    logic [OUT_W-1:0] warning_total;
    logic [OUT_W-1:0] info_total;
    logic [OUT_W-1:0] lines_passed;
    logic [OUT_W-1:0] lines_total;
    logic             line_shown;
    logic [2:0]       line_class;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

endpackage

FILE: rtl/llkc_line.sv
// line tracker: byte window, keyword and search matching, line close detection
// depends on llkc_pkg
module llkc_line #(
  parameter int LINE_BUFFER  = llkc_pkg::LINE_BUFFER_DEF,
  parameter int SEARCH_CHARS = llkc_pkg::SEARCH_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               action,
  input  logic [7:0]         data_byte,
  input  logic [127:0]       search_chars,
  input  logic [4:0]         search_length,
  output llkc_pkg::line_ev_t ev
);
  import llkc_pkg::*;

  localparam int LEN_W = $clog2(LINE_BUFFER);
  localparam int SL_W  = $clog2(SEARCH_CHARS + 1);

  logic [7:0]       recent [WINDOW];
  logic [3:0]       keyword_hits;
  logic             search_hit;
  logic [LEN_W-1:0] line_length;
  logic             text_ended;
  logic             line_hidden;
  logic [VIS_W-1:0] visible_count;

  logic [7:0]        win [WINDOW+1];
  logic [7:0]        schar [SEARCH_CHARS];
  logic [4:0]        avail;
  logic [4:0]        n_used;
  logic [4:0]        len_eff;
  logic [3:0]        hits_now;
  logic [SEARCH_CHARS:0] match_len;
  logic              hit_now;
  logic              scan;
  logic              is_nl;
  logic              is_nul;
  logic [LEN_W-1:0]  len_inc;
  logic              search_upd;

  always_comb begin
    win[0] = fold(data_byte);
    for (int k = 1; k <= WINDOW; k++) win[k] = recent[k-1];
    for (int j = 0; j < SEARCH_CHARS; j++) schar[j] = fold(search_chars[8*j +: 8]);
  end

  assign avail = 5'({1'b0, visible_count}) + 5'd1;

  always_comb begin
    n_used = (search_length > 5'(SEARCH_CHARS)) ? 5'(SEARCH_CHARS) : search_length;
    len_eff = n_used;
    for (int i = SEARCH_CHARS - 1; i >= 0; i--) begin
      if (5'(i) < n_used && schar[i] == CHAR_NUL) len_eff = 5'(i);
    end
  end

  always_comb begin
    logic ok;
    hits_now = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      ok = KEY_LEN[i] <= avail;
      for (int k = 0; k < KEY_MAX; k++) begin
        if (5'(k) < KEY_LEN[i] && win[k] != KEY_TEXT[i][8*k +: 8]) ok = 1'b0;
      end
      if (ok) hits_now[KEY_CLASS[i]] = 1'b1;
    end
  end

  // match_len[n]: the last n bytes equal the first n search characters
  always_comb begin
    logic ok;
    match_len[0] = 1'b0;
    for (int n = 1; n <= SEARCH_CHARS; n++) begin
      ok = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (win[k] != schar[n-1-k]) ok = 1'b0;
      end
      match_len[n] = ok;
    end
  end

  assign hit_now = (len_eff != 5'd0) && (len_eff <= avail) && match_len[len_eff[SL_W-1:0]];

  assign is_nl   = data_byte == CHAR_LF;
  assign is_nul  = data_byte == CHAR_NUL;
  assign scan    = !action && !is_nl && !is_nul && !line_hidden;
  assign len_inc = line_length + LEN_W'(1);

  assign search_upd = search_hit || (scan && hit_now);
  assign ev.hits    = keyword_hits | (scan ? hits_now : 4'd0);
  assign ev.text_ok = (len_eff == 5'd0) || search_upd;
  assign ev.close   = !text_ended &&
                      (action ? (line_length != '0)
                              : (is_nl || len_inc == LEN_W'(LINE_BUFFER - 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_hits  <= '0;
      search_hit    <= 1'b0;
      line_length   <= '0;
      text_ended    <= 1'b0;
      line_hidden   <= 1'b0;
      visible_count <= '0;
    end else if (step && !text_ended) begin
      if (action) begin
        text_ended <= 1'b1;
      end
      if (ev.close || action) begin
        keyword_hits  <= '0;
        search_hit    <= 1'b0;
        line_length   <= '0;
        line_hidden   <= 1'b0;
        visible_count <= '0;
      end else begin
        keyword_hits <= ev.hits;
        search_hit   <= search_upd;
        line_length  <= len_inc;
        if (is_nul) line_hidden <= 1'b1;
        if (scan && visible_count != VIS_W'(WINDOW)) visible_count <= visible_count + VIS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !text_ended && scan) begin
      recent[0] <= win[0];
      for (int k = 1; k < WINDOW; k++) recent[k] <= recent[k-1];
    end
  end

  `include "log_line_keyword_classifier_core_macros.svh"

  `LLKC_ASSERT_NEXT(a_ended_sticks, text_ended, text_ended, "end of input flag cleared")
  `LLKC_ASSERT_IMPL(a_no_close_after_end, text_ended, !ev.close, "line closed after end")
  `LLKC_ASSERT_NEXT(a_close_clears, step && ev.close, line_length == '0 && keyword_hits == '0,
                    "line state kept after close")

endmodule

FILE: rtl/llkc_tally.sv
// classification, filter decision and saturating line counters
// depends on llkc_pkg
module llkc_tally #(
  parameter int COUNT_BITS = llkc_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  llkc_pkg::line_ev_t ev,
  input  logic [2:0]         type_filter,
  output llkc_pkg::result_t  res
);
  import llkc_pkg::*;

  logic [COUNT_BITS-1:0] line_count;
  logic [COUNT_BITS-1:0] shown_count;
  logic [COUNT_BITS-1:0] class_counts [NUM_CLASSES];

  logic [COUNT_BITS-1:0] line_count_next;
  logic [COUNT_BITS-1:0] shown_count_next;
  logic [COUNT_BITS-1:0] class_counts_next [NUM_CLASSES];
  logic [2:0]            cls;
  logic                  type_ok;
  logic                  shown;

  always_comb begin
    if (ev.hits[0])      cls = CLASS_INFO;
    else if (ev.hits[1]) cls = CLASS_WARNING;
    else if (ev.hits[2]) cls = CLASS_ERROR;
    else if (ev.hits[3]) cls = CLASS_DEBUG;
    else                 cls = CLASS_UNKNOWN;
  end

  always_comb begin
    unique case (type_filter)
      FILT_ALL:     type_ok = 1'b1;
      FILT_ERROR:   type_ok = cls == CLASS_ERROR;
      FILT_WARNING: type_ok = cls == CLASS_WARNING;
      FILT_INFO:    type_ok = cls == CLASS_INFO;
      FILT_DEBUG:   type_ok = cls == CLASS_DEBUG;
      default:      type_ok = 1'b0;
    endcase
  end

  assign shown = type_ok && ev.text_ok;

  always_comb begin
    line_count_next  = (line_count == '1) ? line_count : line_count + COUNT_BITS'(1);
    shown_count_next = (!shown || shown_count == '1) ? shown_count
                                                      : shown_count + COUNT_BITS'(1);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      class_counts_next[c] = (3'(c) != cls || class_counts[c] == '1) ? class_counts[c]
                             : class_counts[c] + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      shown_count <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) class_counts[c] <= '0;
    end else if (step && ev.close) begin
      line_count  <= line_count_next;
      shown_count <= shown_count_next;
      for (int c = 0; c < NUM_CLASSES; c++) class_counts[c] <= class_counts_next[c];
    end
  end

  always_comb begin
    res.line_class    = cls;
    res.line_shown    = shown;
    res.lines_total   = OUT_W'(line_count_next);
    res.lines_passed  = OUT_W'(shown_count_next);
    res.info_total    = OUT_W'(class_counts_next[CLASS_INFO]);
    res.warning_total = OUT_W'(class_counts_next[CLASS_WARNING]);
    res.error_total   = OUT_W'(class_counts_next[CLASS_ERROR]);
    res.debug_total   = OUT_W'(class_counts_next[CLASS_DEBUG]);
    res.unknown_total = OUT_W'(class_counts_next[CLASS_UNKNOWN]);
  end

  `include "log_line_keyword_classifier_core_macros.svh"

  `LLKC_ASSERT_NEXT(a_total_moves, step && ev.close && $past(1'b1) && line_count != '1,
                    line_count != '0, "line count did not advance")
  `LLKC_ASSERT_IMPL(a_passed_le_total, 1'b1, shown_count <= line_count,
                    "more lines shown than closed")
  `LLKC_ASSERT_NEXT(a_idle_holds, !(step && ev.close), $stable(line_count),
                    "line count moved without a close")

endmodule

FILE: rtl/log_line_keyword_classifier_core.sv
// log line keyword classifier: input register, line tracker, tally, result register
// depends on llkc_pkg, llkc_line, llkc_tally and the assertion macro header
//
// bytes arrive on the s_ stream: s_tuser is the action (0 data byte, 1 end of
// input), s_tdata the byte. one byte is taken per cycle while no line-closing
// byte waits for the result register. each closed line gives one transfer on
// the m_ stream with its class, shown flag and saturating counts. a line
// closes on 0x0A, at LINE_BUFFER-1 bytes, or at end of input when not empty.
// a result passes the input register, then the result register. the line
// tracker compares its window and updates its state as each byte advances.
// a stalled m_ side holds its result; bytes that close no line still flow past,
// while a byte that closes a line waits in the input register until the result
// register frees.
// configuration is written by the user through cfg_write/cfg_index/cfg_data
// only while idle; the block does not enforce this. rst (synchronous) clears all
// line state and counters; after end of input every item is dropped until reset.
module log_line_keyword_classifier_core #(
  parameter int LINE_BUFFER  = llkc_pkg::LINE_BUFFER_DEF,
  parameter int SEARCH_CHARS = llkc_pkg::SEARCH_CHARS_DEF,
  parameter int COUNT_BITS   = llkc_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  // line_class[2:0], line_shown[3], lines_total[35:4], lines_passed[67:36],
  // info_total[99:68], warning_total[131:100], error_total[163:132],
  // debug_total[195:164], unknown_total[227:196], zero pad[231:228]
  output logic [231:0] m_tdata,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import llkc_pkg::*;

  logic [2:0]  type_filter;
  logic [63:0] search_chars_low;
  logic [63:0] search_chars_high;
  logic [4:0]  search_length;

  logic        in_valid;
  logic        in_action;
  logic [7:0]  in_byte;
  logic        advance;
  line_ev_t    ev;
  result_t     res;
  result_t     out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_filter       <= '0;
      search_chars_low  <= '0;
      search_chars_high <= '0;
      search_length     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TYPE_FILTER: type_filter       <= cfg_data[2:0];
        REG_CHARS_LOW:   search_chars_low  <= cfg_data;
        REG_CHARS_HIGH:  search_chars_high <= cfg_data;
        REG_SEARCH_LEN:  search_length     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!ev.close || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  llkc_line #(
    .LINE_BUFFER  (LINE_BUFFER),
    .SEARCH_CHARS (SEARCH_CHARS)
  ) u_line (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .action        (in_action),
    .data_byte     (in_byte),
    .search_chars  ({search_chars_high, search_chars_low}),
    .search_length (search_length),
    .ev            (ev)
  );

  llkc_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .ev          (ev),
    .type_filter (type_filter),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && ev.close) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev.close) out_res <= res;
  end

  assign m_tdata = {4'd0, out_res};

  `include "log_line_keyword_classifier_core_macros.svh"

  `LLKC_ASSERT_NEXT(a_close_gives_result, advance && ev.close, m_tvalid,
                    "closed line gave no result")
  `LLKC_ASSERT_NEXT(a_held_item_kept, in_valid && !advance, in_valid,
                    "waiting input item dropped")
  `LLKC_ASSERT_IMPL(a_no_overwrite, m_tvalid && !m_tready, !(advance && ev.close),
                    "result overwritten while stalled")
  `LLKC_ASSERT_IMPL(a_total_nonzero, m_tvalid, out_res.lines_total != '0,
                    "result with zero line total")

endmodule
